FILE: rtl/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// Types and constants shared by the pose interpolator modules.
// ----------------------------------------------------------------------------
package pia_pkg;

   // angle constants in Q3.13
   localparam int AngPi    = 25736;
   localparam int AngTwoPi = 51472;

   // register indexes of the configuration port
   localparam logic [2:0] REG_START_DELAY = 3'd0;
   localparam logic [2:0] REG_MIN_DELAY   = 3'd1;
   localparam logic [2:0] REG_MAX_DELAY   = 3'd2;
   localparam logic [2:0] REG_GAIN        = 3'd3;

   // register reset values
   localparam logic [19:0] START_DELAY_RST = 20'd100000;
   localparam logic [19:0] MIN_DELAY_RST   = 20'd50000;
   localparam logic [19:0] MAX_DELAY_RST   = 20'd250000;
   localparam logic [15:0] GAIN_RST        = 16'd9830;

   // item function codes
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_JIT_A,
      ST_JIT_B,
      ST_JIT_C,
      ST_GAP_A,
      ST_GAP_B,
      ST_GAP_C,
      ST_DELAY,
      ST_FRAC,
      ST_DIV,
      ST_LERP,
      ST_DONE
   } state_type;

   // divider handshake toward the sequencer
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quot;
   } div_status_type;

endpackage

FILE: rtl/pia_mul.sv
// ----------------------------------------------------------------------------
// pia_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pia_mul
   import pia_pkg::*;
(
   input  logic               clock,
   input  logic signed [40:0] op_a,
   input  logic signed [17:0] op_b,
   output logic signed [58:0] prod
);

   logic signed [58:0] prod_ff;
   logic signed [58:0] prod_in;

   // form the product
   assign prod_in = op_a * op_b;

   // register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/pia_div.sv
// ----------------------------------------------------------------------------
// pia_div
// Restoring divider for the fraction: quot = floor(num * 65536 / span),
// one quotient bit per cycle, requires num < span.
// ----------------------------------------------------------------------------
module pia_div
   import pia_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    num,
   input  logic [31:0]    span,
   output div_status_type status
);

   logic [31:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;
   logic [31:0] span_ff, span_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic        fits;

   // one shift and compare step
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = (shifted >= {1'b0, span_ff});
      rem_in  = rem_ff;
      quot_in = quot_ff;
      span_in = span_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         span_in = span;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? 32'(shifted - {1'b0, span_ff}) : shifted[31:0];
         quot_in = {quot_ff[14:0], fits};
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // hold operands
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      span_ff <= span_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.quot = quot_ff;

endmodule

FILE: rtl/pose_interpolator_adaptive_delay.sv
// ----------------------------------------------------------------------------
// pose_interpolator_adaptive_delay
// Two-slot pose buffer with jitter-adaptive delay and interpolation.
// ----------------------------------------------------------------------------
// One item is taken at a time. A push that is stale or the first one goes
// through ST_PUSH, ST_DELAY and ST_DONE; one that updates the gap and jitter
// estimates also passes ST_JIT_A to ST_GAP_C, where they take four passes of
// the shared multiplier. A query goes through ST_DELAY and ST_DONE before
// priming or when both slots hold the same time; else ST_FRAC clamps the
// fraction to 0 or 1 or starts the 16-step restoring divider, and the five
// interpolation products then stream through the same multiplier. The finished
// result sits in an output register, so the next item is taken while it waits;
// the block stalls only if a second result is ready before the first is taken.
module pose_interpolator_adaptive_delay
   import pia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_us, pos_x, pos_y, pos_z, yaw_in, pitch_in (low bit up)
   input  logic [159:0] req_tdata,
   // func
   input  logic         req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z, out_yaw, out_pitch, is_primed, delay_used_us,
   // push_accepted, zero fill (low bit up)
   output logic [151:0] rsp_tdata,
   // configuration port
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   // configuration
   logic [19:0] start_delay_ff, min_delay_ff, max_delay_ff;
   logic [15:0] gain_ff;

   // sequencer
   state_type   state_ff, state_in;
   logic [2:0]  lane_ff, lane_in;

   // latched item
   logic        func_ff;
   logic [31:0] time_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] yaw_ff, pitch_ff;

   // pose slots and estimates
   logic        primed_ff, primed_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, nx_ff, ny_ff, nz_ff;
   logic signed [15:0] oyaw_ff, nyaw_ff, opitch_ff, npitch_ff;
   logic [31:0] otime_ff, ntime_ff;
   logic [39:0] gap_ff, jit_ff;
   logic        load_first, shift_pair, set_jit, set_gap;

   // working registers
   logic [39:0] g0_ff, dev_ff;
   logic [59:0] acc_ff;
   logic [19:0] delay_ff;
   logic [16:0] t_ff, t_in;
   logic        acc_flag_ff, acc_flag_in;
   logic        acc_load, delay_load, res_init, res_write;

   // result registers
   logic signed [31:0] res_x_ff, res_y_ff, res_z_ff;
   logic signed [15:0] res_yaw_ff, res_pitch_ff;
   logic        rsp_valid_ff;
   logic [151:0] rsp_data_ff;
   logic        rsp_load;

   // shared units
   logic signed [40:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [58:0] mul_p;
   logic        div_start;
   div_status_type div_st;

   // arithmetic signals
   logic [16:0] gain_inv;
   logic [59:0] ewma_sum;
   logic [31:0] gap_time;
   logic [39:0] g0_val;
   logic [41:0] delay_sum;
   logic [33:0] delay_raw;
   logic [19:0] delay_hi, delay_clamped;
   logic signed [33:0] num_s;
   logic [31:0] span;
   logic signed [17:0] yaw_diff_raw, yaw_diff;
   logic signed [40:0] lane_diff;
   logic signed [32:0] lane_base;
   logic [2:0]  lane_prev;
   logic signed [58:0] lane_round;
   logic signed [42:0] lane_step;
   logic signed [42:0] lane_sum;
   logic signed [19:0] yaw_res;

   // wrap an angle once toward [-pi, pi]
   function automatic logic signed [19:0] wrap_once(input logic signed [19:0] v);
      logic signed [19:0] r;
      r = v;
      if (r > 20'sd25736) r = r - 20'sd51472;
      else if (r < -20'sd25736) r = r + 20'sd51472;
      return r;
   endfunction

   pia_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   pia_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_s[31:0]),
      .span   (span),
      .status (div_st)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= START_DELAY_RST;
         min_delay_ff   <= MIN_DELAY_RST;
         max_delay_ff   <= MAX_DELAY_RST;
         gain_ff        <= GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_DELAY: start_delay_ff <= csr_wdata;
            REG_MIN_DELAY:   min_delay_ff   <= csr_wdata;
            REG_MAX_DELAY:   max_delay_ff   <= csr_wdata;
            REG_GAIN:        gain_ff        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // estimate and fraction arithmetic
   always_comb begin
      gain_inv     = 17'h10000 - {1'b0, gain_ff};
      ewma_sum     = acc_ff + 60'(unsigned'(mul_p)) + 60'd32768;
      gap_time     = time_ff - ntime_ff;
      g0_val       = {gap_time, 8'd0};
      delay_sum    = {2'b0, gap_ff} + {1'b0, jit_ff, 1'b0} + 42'd128;
      delay_raw    = delay_sum[41:8];
      delay_hi     = (delay_raw > {14'd0, max_delay_ff}) ? max_delay_ff : delay_raw[19:0];
      delay_clamped = !primed_ff ? start_delay_ff :
                      (delay_hi < min_delay_ff) ? min_delay_ff : delay_hi;
      num_s        = $signed({2'b0, time_ff}) - $signed({14'd0, delay_ff})
                     - $signed({2'b0, otime_ff});
      span         = ntime_ff - otime_ff;
      yaw_diff_raw = 18'(nyaw_ff) - 18'(oyaw_ff);
      yaw_diff     = 18'(wrap_once(20'(yaw_diff_raw)));
   end

   // lane selection for interpolation
   always_comb begin
      lane_prev = lane_ff - 3'd1;
      case (lane_ff)
         3'd0:    lane_diff = 41'(33'(nx_ff) - 33'(ox_ff));
         3'd1:    lane_diff = 41'(33'(ny_ff) - 33'(oy_ff));
         3'd2:    lane_diff = 41'(33'(nz_ff) - 33'(oz_ff));
         3'd3:    lane_diff = 41'(yaw_diff);
         3'd4:    lane_diff = 41'(17'(npitch_ff) - 17'(opitch_ff));
         default: lane_diff = '0;
      endcase
      case (lane_prev)
         3'd0:    lane_base = 33'(ox_ff);
         3'd1:    lane_base = 33'(oy_ff);
         3'd2:    lane_base = 33'(oz_ff);
         3'd3:    lane_base = 33'(oyaw_ff);
         3'd4:    lane_base = 33'(opitch_ff);
         default: lane_base = '0;
      endcase
      lane_round = mul_p + 59'sd32768;
      lane_step  = 43'(lane_round >>> 16);
      lane_sum   = 43'(lane_base) + lane_step;
      yaw_res    = wrap_once(lane_sum[19:0]);
   end

   // sequencer: next state and controls
   always_comb begin
      state_in    = state_ff;
      lane_in     = lane_ff;
      t_in        = t_ff;
      acc_flag_in = acc_flag_ff;
      primed_in   = primed_ff;
      load_first  = 1'b0;
      shift_pair  = 1'b0;
      set_jit     = 1'b0;
      set_gap     = 1'b0;
      acc_load    = 1'b0;
      delay_load  = 1'b0;
      res_init    = 1'b0;
      res_write   = 1'b0;
      rsp_load    = 1'b0;
      div_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               acc_flag_in = 1'b0;
               state_in    = (req_tuser == FUNC_PUSH) ? ST_PUSH : ST_DELAY;
            end
         end
         ST_PUSH: begin
            if (!primed_ff) begin
               load_first  = 1'b1;
               primed_in   = 1'b1;
               acc_flag_in = 1'b1;
               state_in    = ST_DELAY;
            end else if (time_ff > ntime_ff) begin
               acc_flag_in = 1'b1;
               state_in    = ST_JIT_A;
            end else begin
               state_in = ST_DELAY;
            end
         end
         ST_JIT_A: begin
            mul_a    = 41'({1'b0, jit_ff});
            mul_b    = 18'({1'b0, gain_inv});
            state_in = ST_JIT_B;
         end
         ST_JIT_B: begin
            acc_load = 1'b1;
            mul_a    = 41'({1'b0, dev_ff});
            mul_b    = 18'({2'b0, gain_ff});
            state_in = ST_JIT_C;
         end
         ST_JIT_C: begin
            set_jit  = 1'b1;
            mul_a    = 41'({1'b0, gap_ff});
            mul_b    = 18'({1'b0, gain_inv});
            state_in = ST_GAP_A;
         end
         ST_GAP_A: begin
            acc_load = 1'b1;
            mul_a    = 41'({1'b0, g0_ff});
            mul_b    = 18'({2'b0, gain_ff});
            state_in = ST_GAP_B;
         end
         ST_GAP_B: begin
            set_gap  = 1'b1;
            state_in = ST_GAP_C;
         end
         ST_GAP_C: begin
            shift_pair = 1'b1;
            state_in   = ST_DELAY;
         end
         ST_DELAY: begin
            delay_load = 1'b1;
            res_init   = 1'b1;
            if (func_ff == FUNC_QUERY && primed_ff && ntime_ff > otime_ff)
               state_in = ST_FRAC;
            else
               state_in = ST_DONE;
         end
         ST_FRAC: begin
            lane_in = '0;
            if (num_s <= 34'sd0) begin
               t_in     = '0;
               state_in = ST_LERP;
            end else if (num_s >= $signed({2'b0, span})) begin
               t_in     = 17'h10000;
               state_in = ST_LERP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               t_in     = {1'b0, div_st.quot};
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            mul_a   = lane_diff;
            mul_b   = 18'({1'b0, t_ff});
            lane_in = lane_ff + 3'd1;
            if (lane_ff != 3'd0) res_write = 1'b1;
            if (lane_ff == 3'd5) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         primed_ff <= primed_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // latch the item and working values
   always_ff @(posedge clock) begin
      lane_ff     <= lane_in;
      t_ff        <= t_in;
      acc_flag_ff <= acc_flag_in;
      if (req_tvalid && req_tready) begin
         func_ff  <= req_tuser;
         time_ff  <= req_tdata[31:0];
         px_ff    <= req_tdata[63:32];
         py_ff    <= req_tdata[95:64];
         pz_ff    <= req_tdata[127:96];
         yaw_ff   <= req_tdata[143:128];
         pitch_ff <= req_tdata[159:144];
      end
      if (state_ff == ST_PUSH) begin
         g0_ff  <= g0_val;
         dev_ff <= (g0_val > gap_ff) ? (g0_val - gap_ff) : (gap_ff - g0_val);
      end
      if (acc_load) acc_ff <= 60'(unsigned'(mul_p));
      if (delay_load) delay_ff <= delay_clamped;
   end

   // pose slots and estimates (reset to zero)
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         nx_ff <= '0; ny_ff <= '0; nz_ff <= '0;
         oyaw_ff <= '0; nyaw_ff <= '0; opitch_ff <= '0; npitch_ff <= '0;
         otime_ff <= '0; ntime_ff <= '0;
         gap_ff <= '0; jit_ff <= '0;
      end else begin
         if (load_first) begin
            ox_ff <= px_ff; oy_ff <= py_ff; oz_ff <= pz_ff;
            nx_ff <= px_ff; ny_ff <= py_ff; nz_ff <= pz_ff;
            oyaw_ff <= yaw_ff; nyaw_ff <= yaw_ff;
            opitch_ff <= pitch_ff; npitch_ff <= pitch_ff;
            otime_ff <= time_ff; ntime_ff <= time_ff;
         end else if (shift_pair) begin
            ox_ff <= nx_ff; oy_ff <= ny_ff; oz_ff <= nz_ff;
            nx_ff <= px_ff; ny_ff <= py_ff; nz_ff <= pz_ff;
            oyaw_ff <= nyaw_ff; nyaw_ff <= yaw_ff;
            opitch_ff <= npitch_ff; npitch_ff <= pitch_ff;
            otime_ff <= ntime_ff; ntime_ff <= time_ff;
         end
         if (set_jit) jit_ff <= ewma_sum[55:16];
         if (set_gap) gap_ff <= ewma_sum[55:16];
      end
   end

   // build the result and drive the output register
   always_ff @(posedge clock) begin
      if (res_init) begin
         res_x_ff     <= nx_ff;
         res_y_ff     <= ny_ff;
         res_z_ff     <= nz_ff;
         res_yaw_ff   <= nyaw_ff;
         res_pitch_ff <= npitch_ff;
      end else if (res_write) begin
         case (lane_prev)
            3'd0:    res_x_ff     <= lane_sum[31:0];
            3'd1:    res_y_ff     <= lane_sum[31:0];
            3'd2:    res_z_ff     <= lane_sum[31:0];
            3'd3:    res_yaw_ff   <= yaw_res[15:0];
            3'd4:    res_pitch_ff <= lane_sum[15:0];
            default: ;
         endcase
      end
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, acc_flag_ff, delay_ff, primed_ff, res_pitch_ff,
                         res_yaw_ff, res_z_ff, res_y_ff, res_x_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a taken item leaves the idle state
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start the sequencer");

   // divider completes only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   // a taken pose always leaves the stream primed
   a_accept_primed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[149]) |-> rsp_tdata[128])
      else $error("accepted push reported as unprimed");

   // estimates change only in an accepted push
   a_est_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(gap_ff) && $stable(jit_ff))
      else $error("estimate changed outside a push");

endmodule
